>>> sv/sid_pkg.sv
package sid_pkg;

  // field widths of the input and result words
  localparam int unsigned LIM_W = 16;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned INT_W = 48;

  // internal fixed-point widths
  localparam int unsigned XQ_W    = 32;  // sample point and step, Q.16
  localparam int unsigned DIFF_W  = LIM_W + 1 + 16;  // |b-a| scaled to Q.16
  localparam int unsigned MUL_W   = 32;  // operand width of the shared multiplier
  localparam int unsigned SQ_FRAC = 16;  // Q.32 square down to Q.16
  localparam int unsigned SQ_W    = 47;  // truncated square, at most 2^46
  localparam int unsigned SCALE_SH = 40; // Q.16 sum times Q.16 step is Q.32

  // weight of a sample, coded as a left shift
  localparam logic [1:0] WSH_END  = 2'd0;
  localparam logic [1:0] WSH_EVEN = 2'd1;
  localparam logic [1:0] WSH_ODD  = 2'd2;

  // the h/3 factor of the rule
  localparam logic [CNT_W-1:0] THIRD_DIVISOR = CNT_W'(3);

endpackage

>>> sv/sid_div.sv
module sid_div #(
  parameter int unsigned DIV_W = 56
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DIV_W-1:0]            dividend_i,
  input  logic [sid_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [DIV_W-1:0]            quotient_o
);

  localparam int unsigned CB_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]          quo_q;
  logic [sid_pkg::CNT_W-1:0] rem_q;
  logic [sid_pkg::CNT_W-1:0] dvs_q;
  logic [CB_W-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [sid_pkg::CNT_W:0]   trial;
  logic                      fits;
  logic [sid_pkg::CNT_W:0]   trial_sub;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial     = {rem_q, quo_q[DIV_W-1]};
    fits      = trial >= {1'b0, dvs_q};
    trial_sub = trial - {1'b0, dvs_q};
  end

  // shift register of quotient bits with a step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= CB_W'(DIV_W);
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        quo_q  <= {quo_q[DIV_W-2:0], fits};
        rem_q  <= fits ? trial_sub[sid_pkg::CNT_W-1:0] : trial[sid_pkg::CNT_W-1:0];
        cnt_q  <= cnt_q - CB_W'(1);
        done_q <= (cnt_q == CB_W'(1));
        if (cnt_q == CB_W'(1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/simpson_integrator_square_unit.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o   | lower_limit_i, upper_limit_i, interval_count_i
// out     | output    | out_valid_o / out_ready_i | integral_o, invalid_count_o
//
// a valid word passes through the bit-serial divider for h, one sample per cycle through the shared
// 32x32 multiplier, a drain of the sample pipeline, the sum times |h| in 32-bit slices and a
// seven-step shift-add divide by three; a rejected count goes straight to the output register
// one word at a time: in_ready_o is high only while the sequencer is idle
// the result sits in an output register; a stalled output holds only the following result
// rst_ni clears the sequencer, the sample pipeline and the output valid flag
module simpson_integrator_square_unit #(
  parameter int unsigned MAX_INTERVALS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sid_pkg::LIM_W-1:0]   lower_limit_i,
  input  logic signed [sid_pkg::LIM_W-1:0]   upper_limit_i,
  input  logic        [sid_pkg::CNT_W-1:0]   interval_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sid_pkg::INT_W-1:0]   integral_o,
  output logic                               invalid_count_o
);

  localparam int unsigned SUM_W   = sid_pkg::SQ_W + 2 + $clog2(MAX_INTERVALS);
  localparam int unsigned NCH     = (SUM_W + sid_pkg::MUL_W - 1) / sid_pkg::MUL_W;
  localparam int unsigned SH_W    = NCH * sid_pkg::MUL_W;
  localparam int unsigned PROD_W  = SH_W + sid_pkg::MUL_W;
  localparam int unsigned DIV3_W  = PROD_W - sid_pkg::SCALE_SH;
  localparam int unsigned DIV_W   = sid_pkg::DIFF_W;
  localparam int unsigned CH_W    = $clog2(NCH + 2);
  localparam int unsigned MP_W    = 2 * sid_pkg::MUL_W;
  localparam int unsigned R3_W    = 5;

  // steps of the divide by three
  localparam logic [2:0] D3_REM  = 3'd5;
  localparam logic [2:0] D3_LAST = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVH,
    ST_LOOP,
    ST_DRAIN,
    ST_MUL,
    ST_DIV3,
    ST_FIN
  } state_e;

  state_e                      state_q;
  logic [sid_pkg::CNT_W-1:0]   n_q;
  logic [sid_pkg::CNT_W-1:0]   i_q;
  logic [sid_pkg::XQ_W-1:0]    x_q;
  logic [sid_pkg::XQ_W-1:0]    habs_q;
  logic                        neg_q;
  logic [sid_pkg::MUL_W-1:0]   ux_q;
  logic [1:0]                  w1_q;
  logic [1:0]                  w2_q;
  logic                        s1_v_q;
  logic                        s2_v_q;
  logic [MP_W-1:0]             mul_q;
  logic [SUM_W-1:0]            sum_q;
  logic [SH_W-1:0]             sumsh_q;
  logic [CH_W-1:0]             ch_q;
  logic [PROD_W-1:0]           prod_q;
  logic [2:0]                  d3_step_q;
  logic [DIV3_W-1:0]           d3_q;
  logic [DIV3_W-1:0]           q3_q;
  logic [R3_W-1:0]             r3_q;
  logic [sid_pkg::INT_W-1:0]   res_q;
  logic                        inv_q;
  logic                        out_valid_q;
  logic [sid_pkg::INT_W-1:0]   integral_q;
  logic                        invalid_q;

  logic                        in_acc;
  logic                        count_bad;
  logic [sid_pkg::LIM_W:0]     diff;
  logic [sid_pkg::LIM_W:0]     diff_mag;
  logic [sid_pkg::DIFF_W-1:0]  hdiv_dividend;
  logic                        div_start;
  logic [DIV_W-1:0]            div_dividend;
  logic [sid_pkg::CNT_W-1:0]   div_divisor;
  logic                        div_done;
  logic [DIV_W-1:0]            div_quot;
  logic [sid_pkg::XQ_W-1:0]    h_step;
  logic [sid_pkg::MUL_W-1:0]   x_abs;
  logic [1:0]                  w_shift;
  logic [sid_pkg::MUL_W-1:0]   mul_a;
  logic [sid_pkg::MUL_W-1:0]   mul_b;
  logic [SUM_W-1:0]            sq_term;
  logic [DIV3_W-1:0]           q3_next;
  logic [DIV3_W+1:0]           q3_x3;
  logic [DIV3_W+1:0]           r3_full;
  logic [R3_W+3:0]             r3_x11;
  logic [DIV3_W-1:0]           q3_fin;
  logic [DIV3_W-1:0]           res_full;

  // input checks and the scaled span |b-a|
  always_comb begin
    in_acc    = in_valid_i && in_ready_o;
    count_bad = (interval_count_i == '0) || interval_count_i[0] ||
                (32'(interval_count_i) > 32'(MAX_INTERVALS));
    diff      = {upper_limit_i[sid_pkg::LIM_W-1], upper_limit_i} -
                {lower_limit_i[sid_pkg::LIM_W-1], lower_limit_i};
    diff_mag  = diff[sid_pkg::LIM_W] ? ((sid_pkg::LIM_W + 1)'(0) - diff) : diff;
    hdiv_dividend = {diff_mag, 16'b0};
  end

  // divider operands: step size |b-a| / n
  always_comb begin
    div_start    = (state_q == ST_IDLE) && in_acc && !count_bad;
    div_dividend = hdiv_dividend;
    div_divisor  = interval_count_i;
  end

  // sample point, weight and multiplier operands
  always_comb begin
    h_step = neg_q ? (sid_pkg::XQ_W'(0) - habs_q) : habs_q;
    x_abs  = x_q[sid_pkg::XQ_W-1] ? (sid_pkg::MUL_W'(0) - x_q) : x_q;
    priority if (i_q == '0 || i_q == n_q) begin
      w_shift = sid_pkg::WSH_END;
    end else if (i_q[0]) begin
      w_shift = sid_pkg::WSH_ODD;
    end else begin
      w_shift = sid_pkg::WSH_EVEN;
    end
    mul_a    = (state_q == ST_MUL) ? sumsh_q[SH_W-1 -: sid_pkg::MUL_W] : ux_q;
    mul_b    = (state_q == ST_MUL) ? habs_q : ux_q;
    sq_term  = SUM_W'(mul_q[sid_pkg::SQ_FRAC +: sid_pkg::SQ_W]) << w2_q;
  end

  // divide by three: shift-add series from below, then a small remainder fix-up
  always_comb begin
    unique case (d3_step_q)
      3'd0:    q3_next = (d3_q >> 2) + (d3_q >> 4);
      3'd1:    q3_next = q3_q + (q3_q >> 4);
      3'd2:    q3_next = q3_q + (q3_q >> 8);
      3'd3:    q3_next = q3_q + (q3_q >> 16);
      default: q3_next = q3_q + (q3_q >> 32);
    endcase
    q3_x3    = (DIV3_W + 2)'(q3_q) + ((DIV3_W + 2)'(q3_q) << 1);
    r3_full  = (DIV3_W + 2)'(d3_q) - q3_x3;
    r3_x11   = ((R3_W + 4)'(r3_q) << 3) + ((R3_W + 4)'(r3_q) << 1) + (R3_W + 4)'(r3_q);
    q3_fin   = q3_q + DIV3_W'(r3_x11 >> 5);
    res_full = neg_q ? (DIV3_W'(0) - q3_fin) : q3_fin;
  end

  sid_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // sequencer, sample pipeline and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      x_q         <= '0;
      habs_q      <= '0;
      neg_q       <= 1'b0;
      ux_q        <= '0;
      w1_q        <= '0;
      w2_q        <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      mul_q       <= '0;
      sum_q       <= '0;
      sumsh_q     <= '0;
      ch_q        <= '0;
      prod_q      <= '0;
      d3_step_q   <= '0;
      d3_q        <= '0;
      q3_q        <= '0;
      r3_q        <= '0;
      res_q       <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      integral_q  <= '0;
      invalid_q   <= 1'b0;
    end else begin
      // shared multiplier, registered every cycle
      mul_q <= MP_W'(mul_a) * MP_W'(mul_b);

      // sample pipeline: square in stage two, weighted add in stage three
      s1_v_q <= (state_q == ST_LOOP);
      s2_v_q <= s1_v_q;
      w2_q   <= w1_q;
      if (s2_v_q) begin
        sum_q <= sum_q + sq_term;
      end

      // output word leaves on its handshake unless a new one replaces it
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q   <= interval_count_i;
            x_q   <= {lower_limit_i, 16'b0};
            neg_q <= diff[sid_pkg::LIM_W];
            if (count_bad) begin
              res_q   <= '0;
              inv_q   <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_DIVH;
            end
          end
        end
        ST_DIVH: begin
          if (div_done) begin
            habs_q  <= div_quot[sid_pkg::XQ_W-1:0];
            i_q     <= '0;
            sum_q   <= '0;
            state_q <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          ux_q   <= x_abs;
          w1_q   <= w_shift;
          x_q    <= x_q + h_step;
          if (i_q == n_q) begin
            state_q <= ST_DRAIN;
          end else begin
            i_q <= i_q + sid_pkg::CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!s1_v_q && !s2_v_q) begin
            sumsh_q <= SH_W'(sum_q);
            prod_q  <= '0;
            ch_q    <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // sum times |h|, one 32-bit slice per cycle, high slice first
          sumsh_q <= sumsh_q << sid_pkg::MUL_W;
          if (ch_q != '0 && ch_q <= CH_W'(NCH)) begin
            prod_q <= (prod_q << sid_pkg::MUL_W) + PROD_W'(mul_q);
          end
          if (ch_q == CH_W'(NCH + 1)) begin
            d3_q      <= prod_q[PROD_W-1:sid_pkg::SCALE_SH];
            d3_step_q <= '0;
            state_q   <= ST_DIV3;
          end else begin
            ch_q <= ch_q + CH_W'(1);
          end
        end
        ST_DIV3: begin
          if (d3_step_q == D3_LAST) begin
            res_q   <= res_full[sid_pkg::INT_W-1:0];
            inv_q   <= 1'b0;
            state_q <= ST_FIN;
          end else begin
            if (d3_step_q == D3_REM) begin
              r3_q <= r3_full[R3_W-1:0];
            end else begin
              q3_q <= q3_next;
            end
            d3_step_q <= d3_step_q + 3'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            integral_q  <= res_q;
            invalid_q   <= inv_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign integral_o      = integral_q;
  assign invalid_count_o = invalid_q;

endmodule

>>> sv/sid_check.sv
module sid_check (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [sid_pkg::INT_W-1:0]   integral_o,
  input logic                               invalid_count_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a rejected count always reports a zero integral
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_count_o |-> integral_o == '0)
    else $error("invalid word with nonzero integral");

  // a taken word leaves the block busy in the following cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after a word was taken");

  // a fresh result appears as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while the sequencer is still busy");

endmodule

bind simpson_integrator_square_unit sid_check u_sid_check (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .integral_o      (integral_o),
  .invalid_count_o (invalid_count_o)
);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sid_pkg::*;

  localparam int unsigned MAX_N = 1024;
  localparam int unsigned N_RANDOM = 560;

  // one word in flight: its limits, its count and the integral it must give
  typedef struct {
    logic signed [LIM_W-1:0] lo_lim;
    logic signed [LIM_W-1:0] hi_lim;
    logic        [CNT_W-1:0] count;
    logic signed [INT_W-1:0] integral;
    logic                    invalid;
  } simpson_word_t;

  // integrals still owed by the block, oldest first
  class simpson_scoreboard;
    simpson_word_t owed[$];
    int unsigned errors;
    int unsigned n_checked;

    function new();
      errors = 0;
      n_checked = 0;
    endfunction

    // composite rule over x squared, Q.16 step and Q.16 squares
    function simpson_word_t simpson_of_square(logic signed [LIM_W-1:0] a,
                                              logic signed [LIM_W-1:0] b,
                                              logic [CNT_W-1:0] n);
      simpson_word_t w;
      longint step;
      longint pt;
      logic [63:0] ux;
      logic [63:0] sq;
      logic [63:0] wsum;
      logic [63:0] mag;
      logic [127:0] prod;
      logic [63:0] res;
      w.lo_lim = a;
      w.hi_lim = b;
      w.count = n;
      w.integral = '0;
      w.invalid = 1'b0;
      if (n == 0 || n[0] || n > MAX_N) begin
        w.invalid = 1'b1;
        return w;
      end
      step = ((longint'(b) - longint'(a)) * 65536) / longint'(n);
      wsum = '0;
      for (int unsigned i = 0; i <= n; i++) begin
        pt = longint'(a) * 65536 + longint'(i) * step;
        ux = (pt < 0) ? 64'(-pt) : 64'(pt);
        sq = (ux * ux) >> SQ_FRAC;
        if (i == 0 || i == n)
          wsum += sq << WSH_END;
        else if (i[0])
          wsum += sq << WSH_ODD;
        else
          wsum += sq << WSH_EVEN;
      end
      mag = (step < 0) ? 64'(-step) : 64'(step);
      prod = {64'b0, wsum} * {64'b0, mag};
      res = 64'(prod >> SCALE_SH) / 64'(THIRD_DIVISOR);
      if (step < 0)
        res = -res;
      w.integral = res[INT_W-1:0];
      return w;
    endfunction

    function void note_word(logic signed [LIM_W-1:0] a, logic signed [LIM_W-1:0] b,
                            logic [CNT_W-1:0] n);
      owed.push_back(simpson_of_square(a, b, n));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [INT_W-1:0] got_int, logic got_inv);
      simpson_word_t w;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result integral %0d invalid %0b", got_int, got_inv));
        return;
      end
      w = owed.pop_front();
      n_checked++;
      if (got_int !== w.integral)
        report($sformatf("a=%0d b=%0d n=%0d integral got %0d want %0d",
                         w.lo_lim, w.hi_lim, w.count, got_int, w.integral));
      if (got_inv !== w.invalid)
        report($sformatf("a=%0d b=%0d n=%0d invalid_count got %0b want %0b",
                         w.lo_lim, w.hi_lim, w.count, got_inv, w.invalid));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [LIM_W-1:0] lower_limit_i = '0;
  logic signed [LIM_W-1:0] upper_limit_i = '0;
  logic        [CNT_W-1:0] interval_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [INT_W-1:0] integral_o;
  logic invalid_count_o;

  simpson_scoreboard sb = new();
  bit quiet = 1'b0;

  simpson_integrator_square_unit #(
    .MAX_INTERVALS(MAX_N)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .lower_limit_i   (lower_limit_i),
    .upper_limit_i   (upper_limit_i),
    .interval_count_i(interval_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .integral_o      (integral_o),
    .invalid_count_o (invalid_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle stretch length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drive one word; entered and left at a falling edge
  task automatic send_word(logic signed [LIM_W-1:0] a, logic signed [LIM_W-1:0] b,
                           logic [CNT_W-1:0] n);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    lower_limit_i    <= a;
    upper_limit_i    <= b;
    interval_count_i <= n;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(a, b, n);
    @(negedge clk_i);
  endtask

  // hold the input off until every owed integral has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.owed.size() != 0);
  endtask

  // random word: mostly valid counts kept small, some large, some rejected
  task automatic pick_word(output logic signed [LIM_W-1:0] a,
                           output logic signed [LIM_W-1:0] b,
                           output logic [CNT_W-1:0] n);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      a = LIM_W'($urandom);
      b = LIM_W'($urandom);
    end else if (r < 7) begin
      a = LIM_W'($urandom);
      b = a + LIM_W'(int'($urandom_range(0, 2047)) - 1024);
    end else if (r < 9) begin
      a = LIM_W'(int'($urandom_range(0, 2047)) - 1024);
      b = LIM_W'(int'($urandom_range(0, 2047)) - 1024);
    end else begin
      a = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      b = $urandom_range(0, 1) ? 16'sh7fff : ($urandom_range(0, 1) ? 16'sh8000 : 16'sh0000);
    end
    r = $urandom_range(0, 99);
    if (r < 70)
      n = CNT_W'(2 * $urandom_range(1, 32));
    else if (r < 82)
      n = CNT_W'(2 * $urandom_range(33, 511));
    else if (r < 85)
      n = CNT_W'(MAX_N);
    else if (r < 92)
      n = CNT_W'($urandom) | CNT_W'(1);
    else if (r < 95)
      n = '0;
    else
      n = CNT_W'($urandom_range(MAX_N + 1, 2047));
  endtask

  // output side: ready with random stalls
  initial begin : out_side
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          hold = idle_len();
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(integral_o, invalid_count_o);
  end

  initial begin : in_side
    logic signed [LIM_W-1:0] a;
    logic signed [LIM_W-1:0] b;
    logic [CNT_W-1:0] n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words: one third, extremes, reversed and equal limits, rejected counts
    send_word(16'sd0, 16'sd256, 11'd4);
    send_word(16'sh8000, 16'sh7fff, 11'd2);
    send_word(16'sh7fff, 16'sh8000, 11'd1024);
    send_word(16'sh8000, 16'sh7fff, 11'd1024);
    send_word(16'sh8000, 16'sh7fff, 11'd1022);
    send_word(16'sh8000, 16'sh8000, 11'd2);
    send_word(16'sd0, 16'sd0, 11'd1024);
    send_word(16'sd256, -16'sd256, 11'd8);
    send_word(-16'sd1, 16'sd1, 11'd2);
    send_word(16'sd12345, -16'sd23456, 11'd6);
    send_word(16'sd100, 16'sd200, 11'd0);
    send_word(16'sd100, 16'sd200, 11'd1);
    send_word(16'sd100, 16'sd200, 11'd1023);
    send_word(16'sd100, 16'sd200, 11'd2047);
    send_word(16'sd100, 16'sd200, 11'd1026);
    send_word(16'sh7fff, 16'sh7fff, 11'd2046);
    send_word(-16'sd300, 16'sd5000, 11'd1024);
    drain();

    // random words, with stretches free of idling
    for (int unsigned k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      if (k == N_RANDOM / 2)
        drain();
      pick_word(a, b, n);
      send_word(a, b, n);
    end
    in_valid_i <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> simpson_integrator_square_unit.f
sv/sid_pkg.sv
sv/sid_div.sv
sv/simpson_integrator_square_unit.sv
sv/sid_check.sv
test/tb_top.sv
